// File: hw/rtl/cstr_pkg.sv
package cstr_pkg;

	// gray level width and the top gray level
	localparam int unsigned PIX_W    = 8;
	localparam logic [PIX_W-1:0] GRAY_TOP = 8'd255;

	// one quotient bit per step; the quotient never exceeds the output span
	localparam int unsigned DIV_STEPS = PIX_W;
	localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

	// configuration port
	localparam int unsigned ADDR_W = 3;
	localparam int unsigned DATA_W = 32;
	localparam logic REG_OUT_MIN = 1'b0;
	localparam logic REG_OUT_MAX = 1'b1;

	// request codes
	localparam logic REQ_MEASURE = 1'b0;
	localparam logic REQ_MAP     = 1'b1;

	// controller to datapath
	typedef struct packed {
		logic measure;   // update tracked min and max from the input beat
		logic load;      // capture a map beat: clamp, span, width, flags
		logic mul;       // form the numerator
		logic div_step;  // one restoring division step
		logic finish;    // round, clamp and load the output register
	} cstr_cmd_t;

endpackage

// File: hw/rtl/cstr_in_if.sv
interface cstr_in_if;
	logic                     valid;
	logic                     ready;
	logic                     req_type;
	logic [cstr_pkg::PIX_W-1:0] pixel;
	logic                     frame_start;

	modport source (output valid, output req_type, output pixel, output frame_start,
		input ready);
	modport sink (input valid, input req_type, input pixel, input frame_start,
		output ready);
endinterface

// File: hw/rtl/cstr_out_if.sv
interface cstr_out_if;
	logic                     valid;
	logic                     ready;
	logic [cstr_pkg::PIX_W-1:0] out_pixel;
	logic                     range_error;

	modport source (output valid, output out_pixel, output range_error, input ready);
	modport sink (input valid, input out_pixel, input range_error, output ready);
endinterface

// File: hw/rtl/cstr_regs.sv
module cstr_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [cstr_pkg::ADDR_W-1:0] paddr,
	input  logic [cstr_pkg::DATA_W-1:0] pwdata,
	output logic [cstr_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	output logic [cstr_pkg::PIX_W-1:0]  out_min,
	output logic [cstr_pkg::PIX_W-1:0]  out_max
);
	import cstr_pkg::*;

	logic [PIX_W-1:0] out_min_q;
	logic [PIX_W-1:0] out_max_q;
	logic             wr_en;
	logic             reg_sel;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite & pready;
	assign reg_sel = paddr[2];

	// register writes in the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_min_q <= '0;
			out_max_q <= GRAY_TOP;
		end else if (wr_en) begin
			case (reg_sel)
				REG_OUT_MIN: out_min_q <= pwdata[PIX_W-1:0];
				REG_OUT_MAX: out_max_q <= pwdata[PIX_W-1:0];
				default:     out_min_q <= out_min_q;
			endcase
		end
	end

	// read mux
	always_comb begin
		prdata = '0;
		case (reg_sel)
			REG_OUT_MIN: prdata[PIX_W-1:0] = out_min_q;
			REG_OUT_MAX: prdata[PIX_W-1:0] = out_max_q;
			default:     prdata = '0;
		endcase
	end

	assign out_min = out_min_q;
	assign out_max = out_max_q;
endmodule

// File: hw/rtl/cstr_ctrl.sv
module cstr_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_req_type,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output cstr_pkg::cstr_cmd_t cmd
);
	import cstr_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_MUL,
		S_DIV,
		S_FIN
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] step_q;
	logic             out_valid_q;
	logic             accept;
	logic             out_free;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid & in_ready;
	assign out_free = ~out_valid_q | out_ready;

	// commands to the datapath
	always_comb begin
		cmd          = '0;
		cmd.measure  = accept & (in_req_type == REQ_MEASURE);
		cmd.load     = accept & (in_req_type == REQ_MAP);
		cmd.mul      = (state_q == S_MUL);
		cmd.div_step = (state_q == S_DIV);
		cmd.finish   = (state_q == S_FIN) & out_free;
	end

	// sequencer and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept && in_req_type == REQ_MAP) begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					step_q  <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					step_q <= step_q + 1'b1;
					if (step_q == CNT_W'(DIV_STEPS - 1)) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
endmodule

// File: hw/rtl/cstr_dp.sv
module cstr_dp (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cstr_pkg::cstr_cmd_t        cmd,
	input  logic [cstr_pkg::PIX_W-1:0] pixel,
	input  logic                       frame_start,
	input  logic [cstr_pkg::PIX_W-1:0] out_min,
	input  logic [cstr_pkg::PIX_W-1:0] out_max,
	output logic [cstr_pkg::PIX_W-1:0] out_pixel,
	output logic                       range_error
);
	import cstr_pkg::*;

	logic [PIX_W-1:0]   dark_q;
	logic [PIX_W-1:0]   bright_q;
	logic [PIX_W-1:0]   diff_q;
	logic [PIX_W-1:0]   span_q;
	logic [PIX_W-1:0]   den_q;
	logic [PIX_W-1:0]   omin_q;
	logic               err_q;
	logic               flat_q;
	logic [PIX_W-1:0]   rem_q;
	logic [PIX_W-1:0]   lo_q;
	logic [PIX_W-1:0]   quo_q;
	logic [PIX_W-1:0]   out_pixel_q;
	logic               range_error_q;
	logic [PIX_W-1:0]   zc;
	logic [PIX_W:0]     trial;
	logic [PIX_W:0]     trial_diff;
	logic               trial_ge;
	logic               round_up;
	logic [PIX_W:0]     level;
	logic [PIX_W-1:0]   level_clamped;
	logic [2*PIX_W-1:0] prod;

	// tracked frame extremes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dark_q   <= GRAY_TOP;
			bright_q <= '0;
		end else if (cmd.measure) begin
			if (frame_start) begin
				dark_q   <= pixel;
				bright_q <= pixel;
			end else begin
				if (pixel < dark_q) begin
					dark_q <= pixel;
				end
				if (pixel > bright_q) begin
					bright_q <= pixel;
				end
			end
		end
	end

	// clamp the pixel into the tracked range
	always_comb begin
		zc = pixel;
		if (pixel < dark_q) begin
			zc = dark_q;
		end else if (pixel > bright_q) begin
			zc = bright_q;
		end
	end

	// one restoring step: bring down the next numerator bit
	assign trial      = {rem_q, lo_q[PIX_W-1]};
	assign trial_diff = trial - {1'b0, den_q};
	assign trial_ge   = (trial >= {1'b0, den_q});

	// round half up from the remainder, then offset and clamp
	assign round_up      = ({rem_q, 1'b0} >= {1'b0, den_q});
	assign level         = {1'b0, omin_q} + {1'b0, quo_q} + {{PIX_W{1'b0}}, round_up};
	assign level_clamped = (level > {1'b0, GRAY_TOP}) ? GRAY_TOP : level[PIX_W-1:0];

	assign prod = diff_q * span_q;

	// map operands, numerator and division
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			diff_q <= zc - dark_q;
			span_q <= out_max - out_min;
			den_q  <= bright_q - dark_q;
			omin_q <= out_min;
			err_q  <= (out_min >= out_max);
			flat_q <= (bright_q <= dark_q);
		end
		if (cmd.mul) begin
			rem_q <= prod[2*PIX_W-1:PIX_W];
			lo_q  <= prod[PIX_W-1:0];
			quo_q <= '0;
		end
		if (cmd.div_step) begin
			rem_q <= trial_ge ? trial_diff[PIX_W-1:0] : trial[PIX_W-1:0];
			lo_q  <= {lo_q[PIX_W-2:0], 1'b0};
			quo_q <= {quo_q[PIX_W-2:0], trial_ge};
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			range_error_q <= err_q;
			if (err_q) begin
				out_pixel_q <= '0;
			end else if (flat_q) begin
				out_pixel_q <= omin_q;
			end else begin
				out_pixel_q <= level_clamped;
			end
		end
	end

	assign out_pixel   = out_pixel_q;
	assign range_error = range_error_q;
endmodule

// File: hw/rtl/contrast_stretch_pixel_mapper_top.sv
// Linear contrast stretch of 8-bit gray pixels. Measure beats (req_type 0) update the
// darkest and brightest pixel in the same cycle they are accepted, so they stream at one
// per clock while no map is in progress and produce no output. A map beat (req_type 1)
// returns one output beat out_min + round((z - darkest) * (out_max - out_min) /
// (brightest - darkest)), with the pixel clamped to the tracked range and exact half-up
// rounding. The map runs through an 8x8 multiply state and an 8-step restoring divider
// that yields one quotient bit per clock; a map beat holds the input closed from
// acceptance until the result is loaded, and the output register lets the next beat
// enter while the result waits. A flat range (brightest <= darkest) gives out_min;
// out_min >= out_max gives range_error with out_pixel 0. out_min lives at byte address 0
// and out_max at 4; write them only while the block is idle.
module contrast_stretch_pixel_mapper_top (
	input  logic                        clk,
	input  logic                        arst_n,
	cstr_in_if.sink                     pix_in,
	cstr_out_if.source                  pix_out,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [cstr_pkg::ADDR_W-1:0] paddr,
	input  logic [cstr_pkg::DATA_W-1:0] pwdata,
	output logic [cstr_pkg::DATA_W-1:0] prdata,
	output logic                        pready
);
	import cstr_pkg::*;

	cstr_cmd_t        cmd;
	logic [PIX_W-1:0] out_min;
	logic [PIX_W-1:0] out_max;

	// configuration registers
	cstr_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.out_min (out_min),
		.out_max (out_max)
	);

	// sequencer
	cstr_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (pix_in.valid),
		.in_req_type (pix_in.req_type),
		.in_ready    (pix_in.ready),
		.out_valid   (pix_out.valid),
		.out_ready   (pix_out.ready),
		.cmd         (cmd)
	);

	// tracking, multiply, divide and rounding
	cstr_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.pixel       (pix_in.pixel),
		.frame_start (pix_in.frame_start),
		.out_min     (out_min),
		.out_max     (out_max),
		.out_pixel   (pix_out.out_pixel),
		.range_error (pix_out.range_error)
	);
endmodule

// File: hw/rtl/cstr_checker.sv
module cstr_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       in_req_type,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [cstr_pkg::PIX_W-1:0] out_pixel,
	input logic                       range_error
);
	import cstr_pkg::*;

	// a pending result stays until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output beat dropped before it was taken");

	// a range error always carries a zero pixel
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && range_error |-> out_pixel == '0)
		else $error("range error with nonzero pixel");

	// a map beat keeps the input closed on the next cycle
	a_map_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_req_type == REQ_MAP |=> !in_ready)
		else $error("input taken while a map is in progress");

	// the input only closes because a map beat was accepted
	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(in_ready) |-> $past(in_valid && in_req_type == REQ_MAP))
		else $error("input closed without a map beat");
endmodule

bind contrast_stretch_pixel_mapper_top cstr_checker u_cstr_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (pix_in.valid),
	.in_ready    (pix_in.ready),
	.in_req_type (pix_in.req_type),
	.out_valid   (pix_out.valid),
	.out_ready   (pix_out.ready),
	.out_pixel   (pix_out.out_pixel),
	.range_error (pix_out.range_error)
);
